/* rtl/core/rpsh_pkg.sv */
// Shared types and constants for the RGB pixel statistics histogrammer.
// Used by the top level.
package rpsh_pkg;

  localparam int HUE_BINS   = 32;
  localparam int COUNT_BITS = 24;
  localparam int SUM_BITS   = 32;

  localparam int LUMA_DEPTH = 256;
  localparam int SAT_DEPTH  = 256;
  localparam int RG_DEPTH   = 511;
  localparam int YB_DEPTH   = 1021;

  localparam int LUMA_AW = $clog2(LUMA_DEPTH);
  localparam int SAT_AW  = $clog2(SAT_DEPTH);
  localparam int HUE_AW  = $clog2(HUE_BINS);
  localparam int RG_AW   = $clog2(RG_DEPTH);
  localparam int YB_AW   = $clog2(YB_DEPTH);

  // Divider sizing: largest numerator of either division, largest divisor.
  localparam int SAT_NUM_MAX = 510 * 255 + 255;
  localparam int HUE_NUM_MAX = 1529 * HUE_BINS;
  localparam int DIV_N_W = $clog2(((SAT_NUM_MAX > HUE_NUM_MAX) ? SAT_NUM_MAX : HUE_NUM_MAX) + 1);
  localparam int DIV_D_W = 11;
  localparam int DIV_C_W = $clog2(DIV_N_W + 1);

  localparam logic [7:0] BRIGHT_LUMA_RST = 8'd230;
  localparam logic [7:0] NEUTRAL_SAT_RST = 8'd25;
  localparam logic [7:0] COLORED_SAT_RST = 8'd38;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    TBL_LUMA   = 3'd0,
    TBL_SAT    = 3'd1,
    TBL_HUE    = 3'd2,
    TBL_RG     = 3'd3,
    TBL_YB     = 3'd4,
    TBL_SCALAR = 3'd5
  } tbl_e;

  typedef enum logic [1:0] {
    CFG_BRIGHT_LUMA = 2'd0,
    CFG_NEUTRAL_SAT = 2'd1,
    CFG_COLORED_SAT = 2'd2
  } cfg_e;

  localparam logic [9:0] SCL_CLIPPED = 10'd0;
  localparam logic [9:0] SCL_BRIGHT  = 10'd1;
  localparam logic [9:0] SCL_COLORED = 10'd2;

endpackage

/* rtl/core/rpsh_if.sv */
// Valid/ready channel interfaces for pixel requests and read responses.
// Depends on nothing but the payload widths of the block.
interface rpsh_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [2:0] table_select;
  logic [9:0] entry_index;

  modport source (output valid, opcode, red, green, blue, table_select, entry_index,
                  input ready);
  modport sink   (input valid, opcode, red, green, blue, table_select, entry_index,
                  output ready);
endinterface

interface rpsh_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;

  modport source (output valid, read_value, input ready);
  modport sink   (input valid, read_value, output ready);
endinterface

/* rtl/core/rpsh_ram.sv */
// Generic single-port RAM with a registered read.
// Standalone; used for every histogram store.
module rpsh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Writes into the array; read data registered, returning the old contents on a write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/core/rgb_pixel_statistics_histogrammer.sv */
// RGB pixel statistics histogrammer: five histogram RAMs and three scalars.
// Depends on rpsh_pkg, rpsh_if and rpsh_ram.
// One request at a time. Accumulate runs through prep, the shared bit-serial divider for
// saturation and, for a colored pixel only, then for hue, then a RAM read and a RAM write;
// read goes through a RAM read to the response register, and clear runs the same clearing
// pass that zeroes the RAMs after reset.
module rgb_pixel_statistics_histogrammer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_wdata_i,
  rpsh_req_if.sink         req_if,
  rpsh_rsp_if.source       rsp_if
);

  localparam int CB = rpsh_pkg::COUNT_BITS;
  localparam int NW = rpsh_pkg::DIV_N_W;
  localparam int DW = rpsh_pkg::DIV_D_W;
  localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_PREP, S_SDIV, S_HDIV, S_RD, S_WR, S_RSP
  } state_e;

  state_e state_q;

  logic [7:0] bright_min_q, neutral_max_q, colored_min_q;
  logic [1:0] op_q;
  logic [7:0] r_q, g_q, b_q;
  logic [2:0] tsel_q;
  logic [9:0] idx_q;
  logic [9:0] clr_q;

  logic [7:0] luma_q, cmax_q, delta_q, sbin_q;
  logic [rpsh_pkg::RG_AW-1:0]  rg_q;
  logic [rpsh_pkg::YB_AW-1:0]  yb_q;
  logic [rpsh_pkg::HUE_AW-1:0] hbin_q;
  logic [10:0] hnum_q;
  logic clip_q, bright_q, colored_q;

  logic [NW-1:0] div_num_q;
  logic [DW-1:0] div_den_q, div_rem_q;
  logic [rpsh_pkg::DIV_C_W-1:0] div_cnt_q;

  logic [CB-1:0] clipped_q, bneut_q;
  logic [rpsh_pkg::SUM_BITS-1:0] csum_q;

  logic [31:0] rsp_data_q;
  logic        rsp_valid_q;

  // Pixel features, computed from the captured channels.
  logic [17:0] luma_raw;
  logic [7:0]  cmax, cmin, delta;
  logic [15:0] d255, nprod, cprod;
  logic signed [11:0] hs, hs_adj;
  logic [NW-1:0] sat_num;

  always_comb begin
    luma_raw = 18'd218 * 18'(r_q) + 18'd732 * 18'(g_q) + 18'd74 * 18'(b_q);
    cmax = (r_q > g_q) ? r_q : g_q;
    if (b_q > cmax) cmax = b_q;
    cmin = (r_q < g_q) ? r_q : g_q;
    if (b_q < cmin) cmin = b_q;
    delta = cmax - cmin;
    d255  = 16'(delta) * 16'd255;
    nprod = 16'(neutral_max_q) * 16'(cmax);
    cprod = 16'(colored_min_q) * 16'(cmax);
    if (r_q == cmax) begin
      hs = $signed({4'b0, g_q}) - $signed({4'b0, b_q});
    end else if (g_q == cmax) begin
      hs = $signed({3'b0, delta, 1'b0}) + $signed({4'b0, b_q}) - $signed({4'b0, r_q});
    end else begin
      hs = $signed({2'b0, delta, 2'b0}) + $signed({4'b0, r_q}) - $signed({4'b0, g_q});
    end
    hs_adj = (hs < 0) ? hs + $signed(12'(delta) * 12'd6) : hs;
    sat_num = NW'(18'(delta) * 18'd510 + 18'(cmax));
  end

  // One restoring division step: one quotient bit per cycle.
  logic [DW:0]   rem_ext;
  logic          div_ge;
  logic [DW-1:0] rem_next;
  always_comb begin
    rem_ext  = {div_rem_q, div_num_q[NW-1]};
    div_ge   = rem_ext >= {1'b0, div_den_q};
    rem_next = div_ge ? DW'(rem_ext - {1'b0, div_den_q}) : DW'(rem_ext);
  end

  // RAM address and write control.
  logic is_clr, is_rd_op, acc_we;
  logic [CB-1:0] luma_rd, sat_rd, hue_rd, rg_rd, yb_rd;
  logic [rpsh_pkg::LUMA_AW-1:0] luma_a;
  logic [rpsh_pkg::SAT_AW-1:0]  sat_a;
  logic [rpsh_pkg::HUE_AW-1:0]  hue_a;
  logic [rpsh_pkg::RG_AW-1:0]   rg_a;
  logic [rpsh_pkg::YB_AW-1:0]   yb_a;
  logic luma_we, sat_we, hue_we, rg_we, yb_we;

  function automatic logic [CB-1:0] bump(input logic [CB-1:0] c);
    return (c == COUNT_MAX) ? c : c + CB'(1);
  endfunction

  always_comb begin
    is_clr   = state_q == S_CLR;
    is_rd_op = op_q == rpsh_pkg::OP_READ;
    acc_we   = state_q == S_WR;
    if (is_clr) begin
      luma_a = clr_q[rpsh_pkg::LUMA_AW-1:0];
      sat_a  = clr_q[rpsh_pkg::SAT_AW-1:0];
      hue_a  = clr_q[rpsh_pkg::HUE_AW-1:0];
      rg_a   = clr_q[rpsh_pkg::RG_AW-1:0];
      yb_a   = clr_q[rpsh_pkg::YB_AW-1:0];
    end else if (is_rd_op) begin
      luma_a = idx_q[rpsh_pkg::LUMA_AW-1:0];
      sat_a  = idx_q[rpsh_pkg::SAT_AW-1:0];
      hue_a  = idx_q[rpsh_pkg::HUE_AW-1:0];
      rg_a   = idx_q[rpsh_pkg::RG_AW-1:0];
      yb_a   = idx_q[rpsh_pkg::YB_AW-1:0];
    end else begin
      luma_a = luma_q;
      sat_a  = sbin_q;
      hue_a  = hbin_q;
      rg_a   = rg_q;
      yb_a   = yb_q;
    end
    luma_we = (is_clr && clr_q < 10'(rpsh_pkg::LUMA_DEPTH)) || acc_we;
    sat_we  = (is_clr && clr_q < 10'(rpsh_pkg::SAT_DEPTH)) || acc_we;
    hue_we  = (is_clr && clr_q < 10'(rpsh_pkg::HUE_BINS)) || (acc_we && colored_q);
    rg_we   = (is_clr && clr_q < 10'(rpsh_pkg::RG_DEPTH)) || acc_we;
    yb_we   = (is_clr && clr_q < 10'(rpsh_pkg::YB_DEPTH)) || acc_we;
  end

  rpsh_ram #(.WIDTH(CB), .DEPTH(rpsh_pkg::LUMA_DEPTH)) u_luma_ram (
    .clk_i, .we_i(luma_we), .addr_i(luma_a),
    .wdata_i(is_clr ? '0 : bump(luma_rd)), .rdata_o(luma_rd));
  rpsh_ram #(.WIDTH(CB), .DEPTH(rpsh_pkg::SAT_DEPTH)) u_sat_ram (
    .clk_i, .we_i(sat_we), .addr_i(sat_a),
    .wdata_i(is_clr ? '0 : bump(sat_rd)), .rdata_o(sat_rd));
  rpsh_ram #(.WIDTH(CB), .DEPTH(rpsh_pkg::HUE_BINS)) u_hue_ram (
    .clk_i, .we_i(hue_we), .addr_i(hue_a),
    .wdata_i(is_clr ? '0 : bump(hue_rd)), .rdata_o(hue_rd));
  rpsh_ram #(.WIDTH(CB), .DEPTH(rpsh_pkg::RG_DEPTH)) u_rg_ram (
    .clk_i, .we_i(rg_we), .addr_i(rg_a),
    .wdata_i(is_clr ? '0 : bump(rg_rd)), .rdata_o(rg_rd));
  rpsh_ram #(.WIDTH(CB), .DEPTH(rpsh_pkg::YB_DEPTH)) u_yb_ram (
    .clk_i, .we_i(yb_we), .addr_i(yb_a),
    .wdata_i(is_clr ? '0 : bump(yb_rd)), .rdata_o(yb_rd));

  // Response selection with range checks.
  logic [31:0] rd_sel;
  always_comb begin
    rd_sel = '0;
    case (tsel_q)
      rpsh_pkg::TBL_LUMA: if (idx_q < 10'(rpsh_pkg::LUMA_DEPTH)) rd_sel = 32'(luma_rd);
      rpsh_pkg::TBL_SAT:  if (idx_q < 10'(rpsh_pkg::SAT_DEPTH))  rd_sel = 32'(sat_rd);
      rpsh_pkg::TBL_HUE:  if (idx_q < 10'(rpsh_pkg::HUE_BINS))   rd_sel = 32'(hue_rd);
      rpsh_pkg::TBL_RG:   if (idx_q < 10'(rpsh_pkg::RG_DEPTH))   rd_sel = 32'(rg_rd);
      rpsh_pkg::TBL_YB:   if (idx_q < 10'(rpsh_pkg::YB_DEPTH))   rd_sel = 32'(yb_rd);
      rpsh_pkg::TBL_SCALAR: begin
        if (idx_q == rpsh_pkg::SCL_CLIPPED) rd_sel = 32'(clipped_q);
        else if (idx_q == rpsh_pkg::SCL_BRIGHT) rd_sel = 32'(bneut_q);
        else if (idx_q == rpsh_pkg::SCL_COLORED) rd_sel = 32'(csum_q);
      end
      default: rd_sel = '0;
    endcase
  end

  logic [32:0] csum_add;
  logic [NW-1:0] hue_num;
  assign csum_add = {1'b0, csum_q} + 33'(sbin_q);
  assign hue_num  = NW'(hnum_q) * NW'(rpsh_pkg::HUE_BINS);

  assign req_if.ready = state_q == S_IDLE;
  assign rsp_if.valid = rsp_valid_q;
  assign rsp_if.read_value = rsp_data_q;

  // Sequencer, configuration, scalars and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLR;
      clr_q         <= '0;
      bright_min_q  <= rpsh_pkg::BRIGHT_LUMA_RST;
      neutral_max_q <= rpsh_pkg::NEUTRAL_SAT_RST;
      colored_min_q <= rpsh_pkg::COLORED_SAT_RST;
      clipped_q     <= '0;
      bneut_q       <= '0;
      csum_q        <= '0;
      rsp_valid_q   <= 1'b0;
      op_q          <= rpsh_pkg::OP_NONE;
      div_cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rpsh_pkg::CFG_BRIGHT_LUMA: bright_min_q  <= cfg_wdata_i;
          rpsh_pkg::CFG_NEUTRAL_SAT: neutral_max_q <= cfg_wdata_i;
          rpsh_pkg::CFG_COLORED_SAT: colored_min_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      // The response state reloads the register itself when it frees up.
      if (rsp_valid_q && rsp_if.ready && state_q != S_RSP) rsp_valid_q <= 1'b0;

      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 10'd1;
          if (clr_q == 10'(rpsh_pkg::YB_DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req_if.valid) begin
            op_q   <= req_if.opcode;
            r_q    <= req_if.red;
            g_q    <= req_if.green;
            b_q    <= req_if.blue;
            tsel_q <= req_if.table_select;
            idx_q  <= req_if.entry_index;
            case (req_if.opcode)
              rpsh_pkg::OP_ACCUM: state_q <= S_PREP;
              rpsh_pkg::OP_READ:  state_q <= S_RD;
              rpsh_pkg::OP_CLEAR: begin
                clipped_q <= '0;
                bneut_q   <= '0;
                csum_q    <= '0;
                clr_q     <= '0;
                state_q   <= S_CLR;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_PREP: begin
          luma_q    <= luma_raw[17:10];
          cmax_q    <= cmax;
          delta_q   <= delta;
          clip_q    <= (r_q == 8'hFF) || (g_q == 8'hFF) || (b_q == 8'hFF);
          bright_q  <= (luma_raw[17:10] >= bright_min_q) && (d255 <= nprod);
          colored_q <= (delta != 8'd0) && (d255 > cprod);
          rg_q      <= rpsh_pkg::RG_AW'(10'(r_q) + 10'd255 - 10'(g_q));
          yb_q      <= rpsh_pkg::YB_AW'(11'(r_q) + 11'(g_q) + 11'd510 - {2'b0, b_q, 1'b0});
          hnum_q    <= hs_adj[10:0];
          div_num_q <= sat_num;
          div_den_q <= DW'({cmax, 1'b0});
          div_rem_q <= '0;
          div_cnt_q <= rpsh_pkg::DIV_C_W'(NW);
          state_q   <= S_SDIV;
        end
        S_SDIV, S_HDIV: begin
          if (div_cnt_q != '0) begin
            div_num_q <= {div_num_q[NW-2:0], div_ge};
            div_rem_q <= rem_next;
            div_cnt_q <= div_cnt_q - 1'b1;
          end else if (state_q == S_SDIV) begin
            if (cmax_q == 8'd0) sbin_q <= '0;
            else if (div_num_q > NW'(255)) sbin_q <= 8'hFF;
            else sbin_q <= div_num_q[7:0];
            div_num_q <= hue_num;
            div_den_q <= DW'(11'(delta_q) * 11'd6);
            div_rem_q <= '0;
            div_cnt_q <= rpsh_pkg::DIV_C_W'(NW);
            state_q   <= colored_q ? S_HDIV : S_RD;
          end else begin
            if (div_num_q > NW'(rpsh_pkg::HUE_BINS - 1)) begin
              hbin_q <= rpsh_pkg::HUE_AW'(rpsh_pkg::HUE_BINS - 1);
            end else begin
              hbin_q <= div_num_q[rpsh_pkg::HUE_AW-1:0];
            end
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= is_rd_op ? S_RSP : S_WR;
        S_WR: begin
          if (clip_q) clipped_q <= bump(clipped_q);
          if (bright_q) bneut_q <= bump(bneut_q);
          if (colored_q) csum_q <= csum_add[32] ? '1 : csum_add[31:0];
          state_q <= S_IDLE;
        end
        S_RSP: begin
          if (!rsp_valid_q || rsp_if.ready) begin
            rsp_data_q  <= rd_sel;
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
